@@ hdl/bqlp_pkg.sv @@
// shared types, widths and the microprogram for the biquad low-pass filter
// no dependencies; imported by bqlp_mac, biquad_lowpass_direct_form_two and the testbench
package bqlp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 20;
    localparam int NODE_W    = 48;
    localparam int FRAC      = 16;
    localparam int HALF_W    = NODE_W / 2;
    localparam int MUL_W     = COEF_W + HALF_W + 1;
    localparam int PART_W    = COEF_W + NODE_W;
    localparam int ACC_W     = 54;
    localparam int STEP_W    = 4;
    localparam int NUM_REGS  = 5;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coef_set;

    localparam t_coef COEF_ONE = t_coef'(1 << FRAC);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2
    } t_reg_idx;

    typedef enum logic [2:0] {CS_B0, CS_B1, CS_B2, CS_A1, CS_A2} t_csel;
    typedef enum logic [1:0] {WS_W0, WS_W1, WS_W2} t_wsel;
    typedef enum logic {HALF_LO, HALF_HI} t_half;
    typedef enum logic [1:0] {PART_NONE, PART_LOAD, PART_ADDHI} t_part_op;
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOADX,
        ACC_SUB,
        ACC_ADD,
        ACC_NODE,
        ACC_OUT
    } t_acc_op;
    typedef enum logic {FLOW_NEXT, FLOW_END} t_flow;

    typedef enum logic {SEQ_IDLE, SEQ_RUN} t_seq_state;

    typedef struct packed {
        logic     mul_en;
        t_csel    csel;
        t_wsel    wsel;
        t_half    half;
        t_part_op part_op;
        t_acc_op  acc_op;
        t_flow    flow;
    } t_uop;

    function automatic t_uop mk_uop(input logic me, input t_csel c, input t_wsel w,
                                    input t_half h, input t_part_op p, input t_acc_op a,
                                    input t_flow f);
        t_uop u;
        u.mul_en  = me;
        u.csel    = c;
        u.wsel    = w;
        u.half    = h;
        u.part_op = p;
        u.acc_op  = a;
        u.flow    = f;
        return u;
    endfunction

    // each product takes a low-half and a high-half pass, overlapped with the next one
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            STEP_W'(0):  u = mk_uop(1'b1, CS_A1, WS_W1, HALF_LO, PART_NONE,  ACC_LOADX, FLOW_NEXT);
            STEP_W'(1):  u = mk_uop(1'b1, CS_A1, WS_W1, HALF_HI, PART_LOAD,  ACC_NONE,  FLOW_NEXT);
            STEP_W'(2):  u = mk_uop(1'b1, CS_A2, WS_W2, HALF_LO, PART_ADDHI, ACC_NONE,  FLOW_NEXT);
            STEP_W'(3):  u = mk_uop(1'b1, CS_A2, WS_W2, HALF_HI, PART_LOAD,  ACC_SUB,   FLOW_NEXT);
            STEP_W'(4):  u = mk_uop(1'b0, CS_A2, WS_W2, HALF_LO, PART_ADDHI, ACC_NONE,  FLOW_NEXT);
            STEP_W'(5):  u = mk_uop(1'b0, CS_A2, WS_W2, HALF_LO, PART_NONE,  ACC_SUB,   FLOW_NEXT);
            STEP_W'(6):  u = mk_uop(1'b0, CS_B0, WS_W0, HALF_LO, PART_NONE,  ACC_NODE,  FLOW_NEXT);
            STEP_W'(7):  u = mk_uop(1'b1, CS_B0, WS_W0, HALF_LO, PART_NONE,  ACC_NONE,  FLOW_NEXT);
            STEP_W'(8):  u = mk_uop(1'b1, CS_B0, WS_W0, HALF_HI, PART_LOAD,  ACC_NONE,  FLOW_NEXT);
            STEP_W'(9):  u = mk_uop(1'b1, CS_B1, WS_W1, HALF_LO, PART_ADDHI, ACC_NONE,  FLOW_NEXT);
            STEP_W'(10): u = mk_uop(1'b1, CS_B1, WS_W1, HALF_HI, PART_LOAD,  ACC_ADD,   FLOW_NEXT);
            STEP_W'(11): u = mk_uop(1'b1, CS_B2, WS_W2, HALF_LO, PART_ADDHI, ACC_NONE,  FLOW_NEXT);
            STEP_W'(12): u = mk_uop(1'b1, CS_B2, WS_W2, HALF_HI, PART_LOAD,  ACC_ADD,   FLOW_NEXT);
            STEP_W'(13): u = mk_uop(1'b0, CS_B2, WS_W2, HALF_LO, PART_ADDHI, ACC_NONE,  FLOW_NEXT);
            STEP_W'(14): u = mk_uop(1'b0, CS_B2, WS_W2, HALF_LO, PART_NONE,  ACC_ADD,   FLOW_NEXT);
            STEP_W'(15): u = mk_uop(1'b0, CS_B2, WS_W2, HALF_LO, PART_NONE,  ACC_OUT,   FLOW_END);
            default:     u = mk_uop(1'b0, CS_B0, WS_W0, HALF_LO, PART_NONE,  ACC_NONE,  FLOW_END);
        endcase
        return u;
    endfunction

endpackage

@@ hdl/bqlp_mac.sv @@
// shared multiply-accumulate datapath of the biquad: delay nodes, accumulator, clamps
// depends on bqlp_pkg; driven one control word per cycle by the top-level sequencer while it is not stalled
module bqlp_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic signed [bqlp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_restart,
    input  bqlp_pkg::t_uop                      i_uop,
    input  logic                                i_go,
    input  bqlp_pkg::t_coef_set                 i_coef,
    output logic signed [bqlp_pkg::SAMPLE_W-1:0] o_filtered,
    output logic                                o_clipped
);
    import bqlp_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC - 1);

    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [NODE_W-1:0]   r_w0, r_w1, r_w2;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [MUL_W-1:0]    r_prod;
    logic signed [PART_W-1:0]   r_part;
    logic                       r_clip;

    t_coef                      coef_sel;
    logic signed [NODE_W-1:0]   node_sel;
    logic signed [HALF_W:0]     op_b;
    logic signed [MUL_W-1:0]    product;
    logic signed [PART_W-1:0]   prod_ext;
    logic signed [PART_W-1:0]   part_shr;
    logic signed [ACC_W-1:0]    term;
    logic signed [NODE_W-1:0]   node_val;
    logic                       node_hit;
    logic                       out_hit;

    always_comb begin
        case (i_uop.csel)
            CS_B0:   coef_sel = i_coef.b0;
            CS_B1:   coef_sel = i_coef.b1;
            CS_B2:   coef_sel = i_coef.b2;
            CS_A1:   coef_sel = i_coef.a1;
            CS_A2:   coef_sel = i_coef.a2;
            default: coef_sel = i_coef.b0;
        endcase
        case (i_uop.wsel)
            WS_W0:   node_sel = r_w0;
            WS_W1:   node_sel = r_w1;
            WS_W2:   node_sel = r_w2;
            default: node_sel = r_w0;
        endcase
    end

    // low half unsigned, high half signed
    assign op_b     = (i_uop.half == HALF_LO) ? {1'b0, node_sel[HALF_W-1:0]}
                                              : {node_sel[NODE_W-1], node_sel[NODE_W-1:HALF_W]};
    assign product  = MUL_W'(coef_sel) * MUL_W'(op_b);
    assign prod_ext = {{(PART_W-MUL_W){r_prod[MUL_W-1]}}, r_prod};
    // floor of the exact product, back to sixteen fraction bits
    assign part_shr = r_part >>> FRAC;
    assign term     = part_shr[ACC_W-1:0];

    always_comb begin
        node_hit = !((&r_acc[ACC_W-1:NODE_W-1]) || !(|r_acc[ACC_W-1:NODE_W-1]));
        if (!node_hit) begin
            node_val = r_acc[NODE_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            node_val = {1'b1, {(NODE_W-1){1'b0}}};
        end else begin
            node_val = {1'b0, {(NODE_W-1){1'b1}}};
        end
        out_hit = !((&r_acc[ACC_W-1:FRAC+SAMPLE_W-1]) || !(|r_acc[ACC_W-1:FRAC+SAMPLE_W-1]));
        if (!out_hit) begin
            o_filtered = r_acc[FRAC+SAMPLE_W-1:FRAC];
        end else if (r_acc[ACC_W-1]) begin
            o_filtered = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_filtered = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        o_clipped = r_clip | out_hit;
    end

    // delay nodes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= '0;
            r_w2 <= '0;
        end else if (i_load && i_restart) begin
            r_w1 <= '0;
            r_w2 <= '0;
        end else if (i_go && i_uop.acc_op == ACC_OUT) begin
            r_w2 <= r_w1;
            r_w1 <= r_w0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_sample;
        end
        if (i_go && i_uop.mul_en) begin
            r_prod <= product;
        end
        if (i_go) begin
            case (i_uop.part_op)
                PART_LOAD:  r_part <= prod_ext;
                PART_ADDHI: r_part <= r_part + (prod_ext <<< HALF_W);
                default:    r_part <= r_part;
            endcase
            case (i_uop.acc_op)
                ACC_LOADX: begin
                    r_acc  <= {{(ACC_W-SAMPLE_W-FRAC){r_x[SAMPLE_W-1]}}, r_x, {FRAC{1'b0}}};
                    r_clip <= 1'b0;
                end
                ACC_SUB: r_acc <= r_acc - term;
                ACC_ADD: r_acc <= r_acc + term;
                ACC_NODE: begin
                    r_w0   <= node_val;
                    r_clip <= r_clip | node_hit;
                    r_acc  <= ROUND_HALF;
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

endmodule

@@ hdl/biquad_lowpass_direct_form_two.sv @@
// top level of the second-order low-pass biquad, direct form two, fixed point
// depends on bqlp_pkg and bqlp_mac; holds the sequencer, coefficients and output register
//
// usage
//   input stream  : one signed 16-bit sample per transfer on s_axis_tdata, the restart flag
//                   on s_axis_tuser; restart zeroes both delay nodes before that sample
//   output stream : the rounded, saturated result on m_axis_tdata, the clip flag on
//                   m_axis_tuser (node or output saturated for that sample)
//   config        : i_cfg_index selects b0, b1, b2, a1, a2 (0 to 4), i_cfg_data is the
//                   Q3.16 value; o_cfg_ready is always high, other indexes are dropped;
//                   write only while no sample is in flight
//   timing        : a sixteen-step microprogram runs on one shared 20 x 25 multiplier,
//                   two passes per coefficient product; the last step loads the output
//                   register and returns the sequencer to idle, and only then is the next
//                   sample taken, so samples are processed one at a time
//   stall         : if the output register is still full at the last step, the sequencer
//                   holds on that step until the receiver takes the old result
//   reset         : synchronous, active low; clears the delay nodes, sets b0 to one and
//                   the other coefficients to zero, empties the output register
module biquad_lowpass_direct_form_two (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [bqlp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bqlp_pkg::COEF_W-1:0]            i_cfg_data,
    // sample input
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [bqlp_pkg::SAMPLE_W-1:0]          s_axis_tdata,  // [15:0] sample
    input  logic [0:0]                             s_axis_tuser,  // [0] restart
    // filtered output
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [bqlp_pkg::SAMPLE_W-1:0]          m_axis_tdata,  // [15:0] filtered
    output logic [0:0]                             m_axis_tuser   // [0] clipped
);
    import bqlp_pkg::*;

    t_seq_state              r_state, n_state;
    logic [STEP_W-1:0]       r_step, n_step;
    t_coef_set               r_coef;
    logic                    r_out_valid;
    logic [SAMPLE_W-1:0]     r_out_data;
    logic                    r_out_clip;

    t_uop                    uop;
    logic                    in_xfer;
    logic                    slot_free;
    logic                    go;
    logic signed [SAMPLE_W-1:0] mac_filtered;
    logic                    mac_clipped;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == SEQ_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_clip;

    // control word for the current step
    assign uop       = uop_rom(r_step);
    assign slot_free = !r_out_valid || m_axis_tready;

    // sequencer: the last step waits on a free output slot, others always advance
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        go      = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                if (in_xfer) begin
                    n_state = SEQ_RUN;
                    n_step  = '0;
                end
            end
            SEQ_RUN: begin
                if (uop.flow == FLOW_END) begin
                    if (slot_free) begin
                        go      = 1'b1;
                        n_state = SEQ_IDLE;
                        n_step  = '0;
                    end
                end else begin
                    go     = 1'b1;
                    n_step = r_step + STEP_W'(1);
                end
            end
            default: begin
                n_state = SEQ_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.b0 <= COEF_ONE;
            r_coef.b1 <= '0;
            r_coef.b2 <= '0;
            r_coef.a1 <= '0;
            r_coef.a2 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_B0:  r_coef.b0 <= i_cfg_data;
                REG_B1:  r_coef.b1 <= i_cfg_data;
                REG_B2:  r_coef.b2 <= i_cfg_data;
                REG_A1:  r_coef.a1 <= i_cfg_data;
                REG_A2:  r_coef.a2 <= i_cfg_data;
                default: r_coef    <= r_coef;
            endcase
        end
    end

    bqlp_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xfer),
        .i_sample   (s_axis_tdata),
        .i_restart  (s_axis_tuser[0]),
        .i_uop      (uop),
        .i_go       (go),
        .i_coef     (r_coef),
        .o_filtered (mac_filtered),
        .o_clipped  (mac_clipped)
    );

    // output register, loaded by the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && uop.flow == FLOW_END) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && uop.flow == FLOW_END) begin
            r_out_data <= mac_filtered;
            r_out_clip <= mac_clipped;
        end
    end

    // a new sample always starts the program at its first step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == SEQ_RUN) && (r_step == '0))
        else $error("sequencer did not start at step zero");

    // no stray step count while waiting for a sample
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_IDLE) |-> (r_step == '0))
        else $error("step counter not parked while idle");

    // ordinary steps advance by one each cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_RUN) && (uop.flow == FLOW_NEXT) |=>
            (r_step == STEP_W'($past(r_step) + STEP_W'(1))))
        else $error("microprogram step skipped or repeated");

    // finishing a sample leaves a result waiting and frees the input
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (uop.flow == FLOW_END) |=> r_out_valid && (r_state == SEQ_IDLE))
        else $error("finished sample did not reach the output register");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for the direct form two biquad low-pass filter
// needs bqlp_pkg and biquad_lowpass_direct_form_two; a bit-exact filter model in the bench
// predicts every output transfer
module testbench;

    import bqlp_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 40;       // settling margin after the last output transfer
    localparam int  PROD_W       = COEF_W + NODE_W;
    localparam int  RAND_PHASES  = 11;
    localparam int  PHASE_ITEMS  = 150;
    localparam int  MAX_REPORTS  = 10;

    localparam t_coef COEF_MAX = t_coef'(20'h7FFFF);
    localparam t_coef COEF_MIN = t_coef'(20'h80000);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } t_sample_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       clipped;
    } t_filt_res;

    typedef enum logic {ACCUM_ADD, ACCUM_SUB} t_accum_dir;
    typedef enum logic [1:0] {COEF_EXTREME, COEF_WIDE, COEF_SMALL, COEF_LOWPASS} t_coef_mode;

    // clock and reset
    logic i_clk;
    logic i_rst_n = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // block ports, the driven inputs all known from time zero
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [COEF_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [SAMPLE_W-1:0]  s_axis_tdata  = '0;  // [15:0] sample
    logic [0:0]           s_axis_tuser  = '0;  // [0] restart
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]  m_axis_tdata;        // [15:0] filtered
    logic [0:0]           m_axis_tuser;        // [0] clipped

    biquad_lowpass_direct_form_two i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // bench state
    t_sample_item               sample_q[$];    // samples waiting to be offered
    t_filt_res                  filt_exp_q[$];  // predicted outputs, oldest first
    t_coef_set                  coef_model;
    logic signed [NODE_W-1:0]   node_one;       // w1
    logic signed [NODE_W-1:0]   node_two;       // w2
    t_sample_item               offered;
    logic                       offer_busy = 1'b0;
    int                         src_odds   = 0; // 0 means no idling, else 1-in-n chance
    int                         sink_odds  = 0;
    int                         src_gap    = 0;
    int                         sink_gap   = 0;
    int                         err_count  = 0;
    int                         cycle_count = 0;
    int                         n_samples  = 0;
    int                         n_restart  = 0;
    int                         n_clipped  = 0;
    int                         n_cfg      = 0;
    int                         n_settings = 0;

    // ---------------------------------------------------------------------------------------
    // filter model
    // ---------------------------------------------------------------------------------------

    // exact coefficient times node, floored back to 16 fraction bits
    function automatic logic signed [63:0] coef_times_node(input t_coef c,
                                                            input logic signed [NODE_W-1:0] w);
        logic signed [PROD_W-1:0] cx, wx, prod;
        cx   = PROD_W'(c);
        wx   = PROD_W'(w);
        prod = cx * wx;
        return 64'(prod >>> FRAC);
    endfunction

    // 64-bit accumulate with saturation at the 64-bit limits
    function automatic logic signed [63:0] acc_sat(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input t_accum_dir dir);
        logic signed [64:0] ax, bx, s;
        ax = 65'(a);
        bx = 65'(b);
        s  = (dir == ACCUM_SUB) ? ax - bx : ax + bx;
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_width(input logic signed [63:0] v,
                                                        input int bits);
        logic signed [63:0] hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // one sample through the filter, delay nodes move on
    function automatic t_filt_res filter_step(input t_sample_item it);
        logic signed [63:0] acc, node_acc, w0, rounded, y;
        t_filt_res          r;
        if (it.restart) begin
            node_one = '0;
            node_two = '0;
        end
        acc      = 64'($signed(it.sample));
        acc      = acc <<< FRAC;
        acc      = acc_sat(acc, coef_times_node(coef_model.a1, node_one), ACCUM_SUB);
        acc      = acc_sat(acc, coef_times_node(coef_model.a2, node_two), ACCUM_SUB);
        node_acc = acc;
        w0       = clamp_width(node_acc, NODE_W);

        acc      = coef_times_node(coef_model.b0, w0[NODE_W-1:0]);
        acc      = acc_sat(acc, coef_times_node(coef_model.b1, node_one), ACCUM_ADD);
        acc      = acc_sat(acc, coef_times_node(coef_model.b2, node_two), ACCUM_ADD);
        acc      = acc_sat(acc, 64'sd1 <<< (FRAC - 1), ACCUM_ADD);
        rounded  = acc >>> FRAC;
        y        = clamp_width(rounded, SAMPLE_W);

        node_two   = node_one;
        node_one   = w0[NODE_W-1:0];
        r.filtered = y[SAMPLE_W-1:0];
        r.clipped  = (w0 != node_acc) || (y != rounded);
        return r;
    endfunction

    // ---------------------------------------------------------------------------------------
    // sample driver: offers queued samples, predicts each one on its transfer
    // ---------------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            offer_busy = 1'b0;
            src_gap    = 0;
            node_one   = '0;
            node_two   = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                filt_exp_q.push_back(filter_step(offered));
                n_samples++;
                if (offered.restart)
                    n_restart++;
                offer_busy = 1'b0;
            end
            // valid stays high while the same sample waits, so no second write this step
            if (!offer_busy) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    offered = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= offered.sample;
                    s_axis_tuser  <= offered.restart;
                    offer_busy = 1'b1;
                    // idle burst after this sample has gone
                    if (src_odds != 0 && $urandom_range(0, src_odds - 1) == 0)
                        src_gap = $urandom_range(1, 5);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // result monitor with random back-pressure
    // ---------------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_filt_res got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.filtered = m_axis_tdata;
                got.clipped  = m_axis_tuser[0];
                if (got.clipped)
                    n_clipped++;
                if (filt_exp_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("[%0t] output transfer with nothing predicted: %0d clip %0b",
                                 $realtime, got.filtered, got.clipped);
                end else begin
                    want = filt_exp_q.pop_front();
                    if (got.filtered !== want.filtered || got.clipped !== want.clipped) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("[%0t] mismatch: expected %0d clip %0b, got %0d clip %0b",
                                     $realtime, want.filtered, want.clipped,
                                     got.filtered, got.clipped);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (sink_odds != 0 && $urandom_range(0, sink_odds - 1) == 0)
                    sink_gap = $urandom_range(1, 5);
            end
        end
    end

    // coefficient model follows every config transfer, unknown indexes dropped
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_model.b0 <= COEF_ONE;
            coef_model.b1 <= '0;
            coef_model.b2 <= '0;
            coef_model.a1 <= '0;
            coef_model.a2 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            n_cfg++;
            case (i_cfg_index)
                REG_B0:  coef_model.b0 <= i_cfg_data;
                REG_B1:  coef_model.b1 <= i_cfg_data;
                REG_B2:  coef_model.b2 <= i_cfg_data;
                REG_A1:  coef_model.a1 <= i_cfg_data;
                REG_A2:  coef_model.a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, filt_exp_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(input t_coef_set cs, input logic with_spare);
        int idx;
        // writes to unused indexes must leave the coefficients alone
        if (with_spare) begin
            for (idx = NUM_REGS; idx < (1 << CFG_IDX_W); idx++)
                write_reg(CFG_IDX_W'(idx), COEF_W'($urandom()));
        end
        write_reg(REG_B0, cs.b0);
        write_reg(REG_B1, cs.b1);
        write_reg(REG_B2, cs.b2);
        write_reg(REG_A1, cs.a1);
        write_reg(REG_A2, cs.a2);
        n_settings++;
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] s, input logic r);
        t_sample_item it;
        it.sample  = s;
        it.restart = r;
        sample_q.push_back(it);
    endtask

    // block is idle once every offered sample has come back out
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (sample_q.size() != 0 || offer_busy || filt_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_coef pick_coef(input t_coef_mode mode);
        case (mode)
            COEF_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return COEF_ONE;
                    3:       return -COEF_ONE;
                    default: return '0;
                endcase
            end
            COEF_SMALL: return t_coef'(int'($urandom_range(0, 65535)) - 32768);
            default:    return t_coef'($urandom());
        endcase
    endfunction

    // a few stable low-pass designs at different cutoffs
    function automatic t_coef_set lowpass_set(input int which);
        t_coef_set cs;
        case (which)
            0: begin
                cs.b0 = t_coef'(4424);
                cs.b1 = t_coef'(8848);
                cs.b2 = t_coef'(4424);
                cs.a1 = t_coef'(-74907);
                cs.a2 = t_coef'(27054);
            end
            1: begin
                cs.b0 = t_coef'(19195);
                cs.b1 = t_coef'(38390);
                cs.b2 = t_coef'(19195);
                cs.a1 = t_coef'(0);
                cs.a2 = t_coef'(11247);
            end
            default: begin
                cs.b0 = t_coef'(237);
                cs.b1 = t_coef'(474);
                cs.b2 = t_coef'(237);
                cs.a1 = t_coef'(-119454);
                cs.a2 = t_coef'(54866);
            end
        endcase
        return cs;
    endfunction

    function automatic t_sample_item rand_sample();
        t_sample_item it;
        case ($urandom_range(0, 9))
            0:       it.sample = 16'sh7FFF;
            1:       it.sample = 16'sh8000;
            2:       it.sample = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: it.sample = SAMPLE_W'($urandom());
        endcase
        it.restart = ($urandom_range(0, 19) == 0);
        return it;
    endfunction

    // ---------------------------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------------------------
    initial begin
        int         p, k;
        t_coef_set  cs;
        t_coef_mode mode;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients pass the sample straight through
        src_odds  = 4;
        sink_odds = 4;
        @(negedge i_clk);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h5555, 1'b1);
        queue_sample(16'hAAAA, 1'b0);
        wait_drained();

        // extreme coefficients: runaway feedback saturates the nodes, restart recovers
        cs.b0 = COEF_MAX;
        cs.b1 = COEF_MIN;
        cs.b2 = COEF_MAX;
        cs.a1 = COEF_MIN;
        cs.a2 = COEF_MIN;
        load_coefs(cs, 1'b0);
        @(negedge i_clk);
        for (k = 0; k < 6; k++)
            queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h8000, 1'b1);
        for (k = 0; k < 3; k++)
            queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0000, 1'b1);
        wait_drained();

        // most negative gain drives the output into both limits, spare indexes ignored
        cs.b0 = COEF_MIN;
        cs.b1 = '0;
        cs.b2 = '0;
        cs.a1 = '0;
        cs.a2 = '0;
        load_coefs(cs, 1'b1);
        @(negedge i_clk);
        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        wait_drained();

        // random phases, each with its own coefficient set and idling pattern
        for (p = 0; p < RAND_PHASES; p++) begin
            mode = t_coef_mode'(p % 4);
            if (mode == COEF_LOWPASS) begin
                cs = lowpass_set($urandom_range(0, 2));
            end else begin
                cs.b0 = pick_coef(mode);
                cs.b1 = pick_coef(mode);
                cs.b2 = pick_coef(mode);
                cs.a1 = pick_coef(mode);
                cs.a2 = pick_coef(mode);
            end
            load_coefs(cs, $urandom_range(0, 2) == 0);
            case ($urandom_range(0, 3))
                0:       src_odds = 0;
                1:       src_odds = 3;
                2:       src_odds = 6;
                default: src_odds = 12;
            endcase
            case ($urandom_range(0, 3))
                0:       sink_odds = 0;
                1:       sink_odds = 3;
                2:       sink_odds = 6;
                default: sink_odds = 12;
            endcase
            @(negedge i_clk);
            for (k = 0; k < PHASE_ITEMS; k++)
                sample_q.push_back(rand_sample());
            wait_drained();
        end

        // closing stretch at full rate, no idling on either side
        src_odds  = 0;
        sink_odds = 0;
        load_coefs(lowpass_set(0), 1'b0);
        @(negedge i_clk);
        for (k = 0; k < PHASE_ITEMS; k++)
            sample_q.push_back(rand_sample());
        wait_drained();

        $display("covered %0d samples (%0d with restart, %0d outputs clipped)",
                 n_samples, n_restart, n_clipped);
        $display("over %0d coefficient settings from %0d config transfers, %0d mismatches",
                 n_settings, n_cfg, err_count);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
